FILE: design/lsf_pkg.sv
package lsf_pkg;

   localparam int MAX_POINTS_DEF = 1024;

   localparam int PT_W        = 16;
   localparam int FIX_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 11;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 80;
   localparam int DIGIT_W     = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int SLOPE_SHIFT     = 16;
   localparam int INTERCEPT_SHIFT = 8;

   localparam logic [FIX_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
   localparam logic [FIX_W-1:0] FIX_MIN = 32'h8000_0000;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } lsf_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FIT  = 2'd0,
      ST_FEW  = 2'd1,
      ST_FLAT = 2'd2,
      ST_FULL = 2'd3
   } lsf_status_type;

   typedef struct packed {
      lsf_op_type              op;
      logic signed [PT_W-1:0]  x;
      logic signed [PT_W-1:0]  y;
   } lsf_cmd_type;

endpackage

FILE: design/lsf_front.sv
module lsf_front
   import lsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output lsf_cmd_type           cmd
);

   lsf_cmd_type             queue_ff [QUEUE_DEPTH];
   lsf_cmd_type             entry_in;
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         fill_ff, fill_in;
   logic                    push, pop;

   assign req_tready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   assign push = req_tvalid && req_tready;
   assign pop  = cmd_valid && cmd_ready;

   // classify the word: tuser picks clear or add
   always_comb begin
      entry_in.op = req_tuser[0] ? OP_CLEAR : OP_ADD;
      entry_in.x  = req_tdata[PT_W-1:0];
      entry_in.y  = req_tdata[2*PT_W-1:PT_W];
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + (QPTR_W+1)'(1);
         2'b01:   fill_in = fill_ff - (QPTR_W+1)'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

FILE: design/lsf_div.sv
module lsf_div
   import lsf_pkg::*;
#(
   parameter int NUM_W = 77,
   parameter int SHIFT = SLOPE_SHIFT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [NUM_W-1:0] den,
   output logic                    done,
   output logic [FIX_W-1:0]        quot
);

   localparam int DD_W  = NUM_W + 1;
   localparam int N_W   = NUM_W + SHIFT + 2;
   localparam int CMP_W = DD_W + FIX_W;
   localparam int IT_W  = $clog2(FIX_W);

   typedef enum logic [2:0] {
      D_IDLE,
      D_PREP,
      D_CHECK,
      D_RUN,
      D_DONE
   } div_state_type;

   div_state_type       state_ff, state_in;
   logic [NUM_W-1:0]    nm_ff, nm_in;
   logic [NUM_W-1:0]    dm_ff, dm_in;
   logic                sneg_ff, sneg_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic [DD_W-1:0]     dd_ff, dd_in;
   logic [DD_W-1:0]     rem_ff, rem_in;
   logic [FIX_W-1:0]    lo_ff, lo_in;
   logic [FIX_W-1:0]    q_ff, q_in;
   logic                ovf_ff, ovf_in;
   logic [IT_W-1:0]     it_ff, it_in;
   logic                done_ff, done_in;
   logic [FIX_W-1:0]    quot_ff, quot_in;

   logic [DD_W:0]       trial;
   logic [DD_W+1:0]     diff;
   logic                fits;
   logic                big;

   assign done = done_ff;
   assign quot = quot_ff;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign trial = {rem_ff, lo_ff[FIX_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dd_ff};
   assign fits  = !diff[DD_W+1];
   assign big   = ovf_ff || q_ff[FIX_W-1];

   always_comb begin
      state_in = state_ff;
      nm_in    = nm_ff;
      dm_in    = dm_ff;
      sneg_in  = sneg_ff;
      n_in     = n_ff;
      dd_in    = dd_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      it_in    = it_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               nm_in    = num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
               dm_in    = den[NUM_W-1] ? unsigned'(-den) : unsigned'(den);
               sneg_in  = num[NUM_W-1] ^ den[NUM_W-1];
               state_in = D_PREP;
            end
         end
         D_PREP: begin
            // round to nearest: (2|n| * 2^shift + |d|) / (2|d|)
            n_in     = (N_W'(nm_ff) << (SHIFT + 1)) + N_W'(dm_ff);
            dd_in    = {dm_ff, 1'b0};
            state_in = D_CHECK;
         end
         D_CHECK: begin
            // quotient of 2^32 or more saturates either way
            ovf_in   = (CMP_W'(n_ff) >= {dd_ff, {FIX_W{1'b0}}});
            rem_in   = DD_W'(n_ff >> FIX_W);
            lo_in    = n_ff[FIX_W-1:0];
            q_in     = '0;
            it_in    = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            rem_in = fits ? DD_W'(diff) : DD_W'(trial);
            q_in   = {q_ff[FIX_W-2:0], fits};
            lo_in  = lo_ff << 1;
            it_in  = it_ff + IT_W'(1);
            if (it_ff == IT_W'(FIX_W - 1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            if (sneg_ff) begin
               quot_in = big ? FIX_MIN : (~q_ff + FIX_W'(1));
            end else begin
               quot_in = big ? FIX_MAX : q_ff;
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      sneg_ff <= sneg_in;
      n_ff    <= n_in;
      dd_ff   <= dd_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      it_ff   <= it_in;
      quot_ff <= quot_in;
   end

endmodule

FILE: design/lsf_back.sv
module lsf_back
   import lsf_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  lsf_cmd_type           cmd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SX_W   = PT_W + CNT_W;
   localparam int SXY_W  = 2 * PT_W + CNT_W;
   localparam int NDIG   = (SX_W + DIGIT_W - 1) / DIGIT_W;
   localparam int BSH_W  = NDIG * DIGIT_W;
   localparam int ACC_W  = SXY_W + BSH_W;
   localparam int P_W    = ACC_W + 1;
   localparam int NUM_W  = P_W + 1;
   localparam int DIG_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int NPROD  = 6;
   localparam int PIDX_W = $clog2(NPROD);
   localparam int PAD_W  = RSP_DATA_W - 2 * FIX_W - COUNT_OUT_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ,
      S_SUM,
      S_MLOAD,
      S_MRUN,
      S_MSTORE,
      S_DIFF,
      S_ZCHK,
      S_DIV,
      S_EMIT
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic signed [PT_W-1:0]      x_ff, x_in;
   logic signed [PT_W-1:0]      y_ff, y_in;
   logic signed [2*PT_W-1:0]    xy_ff, xy_in;
   logic signed [2*PT_W-1:0]    xx_ff, xx_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [SX_W-1:0]      sx_ff, sx_in;
   logic signed [SX_W-1:0]      sy_ff, sy_in;
   logic signed [SXY_W-1:0]     sxy_ff, sxy_in;
   logic signed [SXY_W-1:0]     sxx_ff, sxx_in;
   logic [FIX_W-1:0]            last_slope_ff, last_slope_in;
   logic [FIX_W-1:0]            last_icpt_ff, last_icpt_in;
   logic [PIDX_W-1:0]           pidx_ff, pidx_in;
   logic [DIG_W-1:0]            dig_ff, dig_in;
   logic [SXY_W-1:0]            mag_a_ff, mag_a_in;
   logic [BSH_W-1:0]            bsh_ff, bsh_in;
   logic                        neg_ff, neg_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic signed [P_W-1:0]       prod_ff [NPROD];
   logic signed [P_W-1:0]       prod_in [NPROD];
   logic signed [NUM_W-1:0]     den_ff, den_in;
   logic signed [NUM_W-1:0]     nums_ff, nums_in;
   logic signed [NUM_W-1:0]     numi_ff, numi_in;
   lsf_status_type              res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [FIX_W-1:0]            rsp_slope_ff, rsp_slope_in;
   logic [FIX_W-1:0]            rsp_icpt_ff, rsp_icpt_in;
   lsf_status_type              rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic signed [SXY_W-1:0]     op_a;
   logic signed [SX_W-1:0]      op_b;
   logic [SX_W-1:0]             mag_b;
   logic [SXY_W+DIGIT_W-1:0]    pp;
   logic signed [P_W-1:0]       acc_s;
   logic                        div_start;
   logic                        s_done, i_done;
   logic [FIX_W-1:0]            s_quot, i_quot;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_count_ff, rsp_icpt_ff, rsp_slope_ff};
   assign rsp_tuser  = rsp_status_ff;

   // operands of the six cross products, in the order they are taken
   always_comb begin
      case (pidx_ff)
         PIDX_W'(0): begin op_a = sxx_ff;             op_b = signed'(SX_W'(count_ff)); end
         PIDX_W'(1): begin op_a = SXY_W'(sx_ff);      op_b = sx_ff;                    end
         PIDX_W'(2): begin op_a = sxy_ff;             op_b = signed'(SX_W'(count_ff)); end
         PIDX_W'(3): begin op_a = SXY_W'(sy_ff);      op_b = sx_ff;                    end
         PIDX_W'(4): begin op_a = sxx_ff;             op_b = sy_ff;                    end
         PIDX_W'(5): begin op_a = sxy_ff;             op_b = sx_ff;                    end
         default:    begin op_a = '0;                 op_b = '0;                       end
      endcase
   end

   assign mag_b = op_b[SX_W-1] ? unsigned'(-op_b) : unsigned'(op_b);
   assign pp    = mag_a_ff * bsh_ff[BSH_W-1 -: DIGIT_W];
   assign acc_s = {1'b0, acc_ff};

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      xy_in         = xy_ff;
      xx_in         = xx_ff;
      count_in      = count_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sxy_in        = sxy_ff;
      sxx_in        = sxx_ff;
      last_slope_in = last_slope_ff;
      last_icpt_in  = last_icpt_ff;
      pidx_in       = pidx_ff;
      dig_in        = dig_ff;
      mag_a_in      = mag_a_ff;
      bsh_in        = bsh_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      nums_in       = nums_ff;
      numi_in       = numi_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slope_in  = rsp_slope_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      cmd_ready     = 1'b0;
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               x_in = cmd.x;
               y_in = cmd.y;
               if (cmd.op == OP_CLEAR) begin
                  count_in = '0;
                  sx_in    = '0;
                  sy_in    = '0;
                  sxy_in   = '0;
                  sxx_in   = '0;
                  res_in   = ST_FEW;
                  state_in = S_EMIT;
               end else if (count_ff >= CNT_W'(MAX_POINTS)) begin
                  res_in   = ST_FULL;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            xy_in    = x_ff * y_ff;
            xx_in    = x_ff * x_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            count_in = count_ff + CNT_W'(1);
            sx_in    = sx_ff + SX_W'(x_ff);
            sy_in    = sy_ff + SX_W'(y_ff);
            sxy_in   = sxy_ff + SXY_W'(xy_ff);
            sxx_in   = sxx_ff + SXY_W'(xx_ff);
            pidx_in  = '0;
            if (count_ff == '0) begin
               res_in   = ST_FEW;
               state_in = S_EMIT;
            end else begin
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            mag_a_in = op_a[SXY_W-1] ? unsigned'(-op_a) : unsigned'(op_a);
            bsh_in   = BSH_W'(mag_b);
            neg_in   = op_a[SXY_W-1] ^ op_b[SX_W-1];
            acc_in   = '0;
            dig_in   = '0;
            state_in = S_MRUN;
         end
         S_MRUN: begin
            // one 16-bit digit of the magnitude per cycle, top digit first
            acc_in = (acc_ff << DIGIT_W) + ACC_W'(pp);
            bsh_in = bsh_ff << DIGIT_W;
            dig_in = dig_ff + DIG_W'(1);
            if (dig_ff == DIG_W'(NDIG - 1)) begin
               state_in = S_MSTORE;
            end
         end
         S_MSTORE: begin
            prod_in[pidx_ff] = neg_ff ? -acc_s : acc_s;
            if (pidx_ff == PIDX_W'(NPROD - 1)) begin
               state_in = S_DIFF;
            end else begin
               pidx_in  = pidx_ff + PIDX_W'(1);
               state_in = S_MLOAD;
            end
         end
         S_DIFF: begin
            den_in   = NUM_W'(prod_ff[0]) - NUM_W'(prod_ff[1]);
            nums_in  = NUM_W'(prod_ff[2]) - NUM_W'(prod_ff[3]);
            numi_in  = NUM_W'(prod_ff[4]) - NUM_W'(prod_ff[5]);
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            if (den_ff == '0) begin
               res_in   = ST_FLAT;
               state_in = S_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (s_done && i_done) begin
               last_slope_in = s_quot;
               last_icpt_in  = i_quot;
               res_in        = ST_FIT;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output word is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_slope_in  = last_slope_ff;
               rsp_icpt_in   = last_icpt_ff;
               rsp_status_in = res_ff;
               rsp_count_in  = COUNT_OUT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         sx_ff         <= '0;
         sy_ff         <= '0;
         sxy_ff        <= '0;
         sxx_ff        <= '0;
         last_slope_ff <= '0;
         last_icpt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sx_ff         <= sx_in;
         sy_ff         <= sy_in;
         sxy_ff        <= sxy_in;
         sxx_ff        <= sxx_in;
         last_slope_ff <= last_slope_in;
         last_icpt_ff  <= last_icpt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      xy_ff         <= xy_in;
      xx_ff         <= xx_in;
      pidx_ff       <= pidx_in;
      dig_ff        <= dig_in;
      mag_a_ff      <= mag_a_in;
      bsh_ff        <= bsh_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      nums_ff       <= nums_in;
      numi_ff       <= numi_in;
      res_ff        <= res_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   lsf_div #(
      .NUM_W (NUM_W),
      .SHIFT (SLOPE_SHIFT)
   ) u_slope_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (nums_ff),
      .den   (den_ff),
      .done  (s_done),
      .quot  (s_quot)
   );

   lsf_div #(
      .NUM_W (NUM_W),
      .SHIFT (INTERCEPT_SHIFT)
   ) u_icpt_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (numi_ff),
      .den   (den_ff),
      .done  (i_done),
      .quot  (i_quot)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above store size");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      s_done == i_done)
      else $error("slope and intercept dividers out of step");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_status_ff == ST_FULL |-> count_ff == CNT_W'(MAX_POINTS))
      else $error("dropped point reported while store not full");

   a_fit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> count_ff >= CNT_W'(2))
      else $error("division started with fewer than two points");

endmodule

FILE: design/least_squares_line_fit.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata: point_x, point_y; tuser: kind
// rsp       out  rsp_tvalid/rsp_tready  tdata: slope, intercept, point_count; tuser: status
//
// A point that yields a fit passes through these steps in order: square and sum, the
// six cross products (one 16-bit digit per cycle), form and test the denominator,
// run the two bit-serial dividers that work side by side, and emit.
// Clears and dropped points go straight to emit; a lone point is emitted once it is summed.
// Reset zeroes the count, the sums and the last fit; no clearing pass follows.
// A two-word queue takes input while the back end computes or the output stalls.
module least_squares_line_fit
   import lsf_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // point_x [15:0], point_y [31:16]
   input  logic [0:0]            req_tuser,   // kind [0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // slope [31:0], intercept [63:32],
                                              // point_count [74:64], zero [79:75]
   output logic [STATUS_W-1:0]   rsp_tuser    // status [1:0]
);

   logic        cmd_valid;
   logic        cmd_ready;
   lsf_cmd_type cmd;

   lsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   lsf_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: dv/least_squares_line_fit_tb.sv
`timescale 1ns / 100ps

module least_squares_line_fit_tb;
   import lsf_pkg::*;

   localparam int POINT_CAPACITY  = MAX_POINTS_DEF;
   localparam int QUIET_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 100;

   typedef struct packed {
      logic [FIX_W-1:0]       slope;
      logic [FIX_W-1:0]       intercept;
      lsf_status_type         status;
      logic [COUNT_OUT_W-1:0] count;
   } fit_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // point_x [15:0], point_y [31:16]
   logic [0:0]            req_tuser = '0;   // kind [0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // slope [31:0], intercept [63:32],
                                            // point_count [74:64], zero [79:75]
   logic [STATUS_W-1:0]   rsp_tuser;        // status [1:0]

   // predictor state
   int          pts_held;
   longint      acc_x, acc_y, acc_xy, acc_xx;
   logic [31:0] slope_held, intercept_held;

   fit_word_type fit_expected[$];
   fit_word_type got_fit, want_fit;

   int mismatches    = 0;
   int words_sent    = 0;
   int clears_sent   = 0;
   int words_checked = 0;
   int status_tally[4] = '{0, 0, 0, 0};
   int quiet_cycles  = 0;

   // sender pacing
   int burst_left = 0;
   bit pace_gaps  = 1'b1;

   // receiver pattern and hold-off
   int         hold_requests = 0;
   int         hold_served   = 0;
   int         hold_left     = 0;
   logic [5:0] sink_phase    = '0;
   int         sink_mode     = 0;

   least_squares_line_fit #(.MAX_POINTS(POINT_CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // round(num * 2^shift / den), ties away from zero, clamped to 32 bits
   function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
                                                   input int shift,
                                                   input logic signed [127:0] den);
      logic         negative;
      logic [127:0] num_mag, den_mag, quo, quo_neg;
      negative = num[127] ^ den[127];
      num_mag  = num[127] ? -num : num;
      den_mag  = den[127] ? -den : den;
      quo      = ((num_mag << (shift + 1)) + den_mag) / (den_mag << 1);
      quo_neg  = -quo;
      if (negative) begin
         return (quo >= 128'h8000_0000) ? FIX_MIN : quo_neg[31:0];
      end
      return (quo > 128'h7FFF_FFFF) ? FIX_MAX : quo[31:0];
   endfunction

   task automatic accumulate_point(input lsf_op_type op, input logic signed [15:0] x,
                                   input logic signed [15:0] y);
      logic signed [127:0] n_w, sx_w, sy_w, sxy_w, sxx_w, den;
      fit_word_type        fit;
      if (op == OP_CLEAR) begin
         pts_held   = 0;
         acc_x      = 0;
         acc_y      = 0;
         acc_xy     = 0;
         acc_xx     = 0;
         fit.status = ST_FEW;
      end else if (pts_held >= POINT_CAPACITY) begin
         fit.status = ST_FULL;
      end else begin
         pts_held++;
         acc_x  += longint'(x);
         acc_y  += longint'(y);
         acc_xy += longint'(x) * longint'(y);
         acc_xx += longint'(x) * longint'(x);
         if (pts_held < 2) begin
            fit.status = ST_FEW;
         end else begin
            n_w   = 128'(pts_held);
            sx_w  = 128'(acc_x);
            sy_w  = 128'(acc_y);
            sxy_w = 128'(acc_xy);
            sxx_w = 128'(acc_xx);
            den   = n_w * sxx_w - sx_w * sx_w;
            if (den == 0) begin
               fit.status = ST_FLAT;
            end else begin
               slope_held     = scaled_quotient(n_w * sxy_w - sx_w * sy_w,
                                                SLOPE_SHIFT, den);
               intercept_held = scaled_quotient(sxx_w * sy_w - sx_w * sxy_w,
                                                INTERCEPT_SHIFT, den);
               fit.status     = ST_FIT;
            end
         end
      end
      fit.slope     = slope_held;
      fit.intercept = intercept_held;
      fit.count     = pts_held[COUNT_OUT_W-1:0];
      fit_expected.push_back(fit);
   endtask

   task automatic send_word(input lsf_op_type op, input logic signed [15:0] x,
                            input logic signed [15:0] y);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = 0;
         if (pace_gaps) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 90)
                                              : $urandom_range(0, 9);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      accumulate_point(op, x, y);
      words_sent++;
      if (op == OP_CLEAR) clears_sent++;
   endtask

   // lower valid and wait until every outstanding fit word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (fit_expected.size() != 0) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input fit_word_type want,
                                input fit_word_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected slope %h intercept %h status %s count %0d",
                  $realtime, what, want.slope, want.intercept, want.status.name(),
                  want.count);
         $display("%0t %s:      got slope %h intercept %h status %s count %0d",
                  $realtime, what, got.slope, got.intercept, got.status.name(),
                  got.count);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_fit.slope     = rsp_tdata[31:0];
         got_fit.intercept = rsp_tdata[63:32];
         got_fit.count     = rsp_tdata[74:64];
         got_fit.status    = lsf_status_type'(rsp_tuser);
         words_checked++;
         status_tally[rsp_tuser]++;
         if (fit_expected.size() == 0) begin
            note_mismatch("fit word with none pending", '0, got_fit);
         end else begin
            want_fit = fit_expected.pop_front();
            if (got_fit.slope !== want_fit.slope ||
                got_fit.intercept !== want_fit.intercept ||
                got_fit.status !== want_fit.status ||
                got_fit.count !== want_fit.count) begin
               note_mismatch("fit word differs", want_fit, got_fit);
            end
         end
      end
   end

   // receiver: a long hold-off on request, otherwise a pattern that changes each time the 6-bit phase wraps
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_OFF_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         sink_phase <= sink_phase + 1'b1;
         if (sink_phase == 0) sink_mode <= $urandom_range(0, 3);
         case (sink_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(0, 1) == 0);
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_tready <= sink_phase[2];
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic test_directed_cases();
      pace_gaps = 1'b1;
      send_word(OP_ADD, 16'sd0, 16'sd0);             // single point: too few
      send_word(OP_ADD, 16'sd0, 16'sh7FFF);          // same x: zero denominator
      send_word(OP_ADD, 16'sd256, 16'sd512);
      send_word(OP_ADD, -16'sd32768, 16'sh7FFF);
      send_word(OP_ADD, 16'sh7FFF, -16'sd32768);
      send_word(OP_CLEAR, -16'sd1, -16'sd1);         // point fields ignored, fit kept
      send_word(OP_ADD, 16'sh7FFF, 16'sh7FFF);
      send_word(OP_ADD, -16'sd32768, -16'sd32768);
      send_word(OP_CLEAR, 16'sd0, 16'sd0);
      send_word(OP_ADD, 16'sd0, -16'sd32768);        // steep rise: slope clamps high
      send_word(OP_ADD, 16'sd1, 16'sh7FFF);
      send_word(OP_CLEAR, 16'sh5555, -16'sh5556);
      send_word(OP_ADD, 16'sd0, 16'sh7FFF);          // steep fall: slope clamps low
      send_word(OP_ADD, 16'sd1, -16'sd32768);
      send_word(OP_CLEAR, 16'sd0, 16'sd0);
      send_word(OP_ADD, 16'sh7FFF, 16'sh7FFF);       // far from origin: intercept clamps
      send_word(OP_ADD, 16'sh7FFE, -16'sd32768);
      send_word(OP_CLEAR, 16'sd0, 16'sd0);
      send_word(OP_ADD, -16'sd1, 16'sd1);
      send_word(OP_ADD, 16'sd1, -16'sd1);
      send_word(OP_ADD, 16'sd0, 16'sd0);
      send_word(OP_ADD, -16'sd32768, 16'sd0);
      send_word(OP_ADD, 16'sd3, 16'sd1);
      drain_results();
   endtask

   task automatic test_random_stream(input int words);
      lsf_op_type  op;
      int          pick, gain, base, span, noise, xv, yv;
      logic [31:0] raw;
      logic signed [15:0] x, y, last_x;
      last_x = '0;
      for (int i = 0; i < words; i++) begin
         if (i % 50 == 0) pace_gaps = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         op   = (pick < 5) ? OP_CLEAR : OP_ADD;
         // each run between clears follows its own noisy line
         if (i == 0 || op == OP_CLEAR) begin
            gain  = int'($urandom_range(0, 1024)) - 512;
            base  = int'($urandom_range(0, 16384)) - 8192;
            span  = (1 << $urandom_range(4, 15)) - 1;
            noise = $urandom_range(0, 300);
         end
         raw = $urandom();
         if (op == OP_CLEAR || pick >= 85) begin
            x = raw[15:0];
            y = raw[31:16];
         end else if (pick < 65) begin
            xv = int'($urandom_range(0, 2 * span)) - span;
            yv = (gain * xv) / 256 + base + int'($urandom_range(0, 2 * noise)) - noise;
            if (yv > 32767) yv = 32767;
            if (yv < -32768) yv = -32768;
            x = xv[15:0];
            y = yv[15:0];
         end else if (pick < 75) begin
            x = last_x;
            y = raw[31:16];
         end else begin
            x = 16'(int'($urandom_range(0, 32)) - 16);
            y = 16'(int'($urandom_range(0, 32)) - 16);
         end
         last_x = x;
         send_word(op, x, y);
      end
      drain_results();
   endtask

   // stall the output long enough that the input queue fills and backs up
   task automatic test_output_backpressure();
      logic [31:0] raw;
      pace_gaps = 1'b0;
      hold_requests++;
      for (int i = 0; i < 12; i++) begin
         raw = $urandom();
         send_word(OP_ADD, raw[15:0], raw[31:16]);
      end
      drain_results();
   endtask

   initial begin
      pts_held       = 0;
      acc_x          = 0;
      acc_y          = 0;
      acc_xy         = 0;
      acc_xx         = 0;
      slope_held     = '0;
      intercept_held = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_stream(210);
      test_output_backpressure();
      test_random_stream(205);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run: %0d words in (%0d clears), %0d fit words checked, %0d mismatches",
               words_sent, clears_sent, words_checked, mismatches);
      $display("Status seen: fit %0d, too few %0d, all x equal %0d, store full %0d",
               status_tally[ST_FIT], status_tally[ST_FEW], status_tally[ST_FLAT],
               status_tally[ST_FULL]);
      if (mismatches == 0 && fit_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/lsf_pkg.sv
design/lsf_front.sv
design/lsf_div.sv
design/lsf_back.sv
design/least_squares_line_fit.sv
dv/least_squares_line_fit_tb.sv
